FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CRS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CRS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types, register codes and constants of the climate relay scheduler.
// ----------------------------------------------------------------------------
package crs_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ON_TEMP      = 3'd0,
    CFG_OFF_TEMP     = 3'd1,
    CFG_HIGH_TEMP    = 3'd2,
    CFG_ON_HUM       = 3'd3,
    CFG_OFF_HUM      = 3'd4,
    CFG_WEB_OVERRIDE = 3'd5,
    CFG_WAIT_FACTOR  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TM_HEAT     = 2'd1,
    TM_HOLD     = 2'd2,
    TM_OVERHEAT = 2'd3
  } temp_mode_t;

  typedef enum logic [1:0] {
    HM_HUMIDIFY = 2'd1,
    HM_HOLD     = 2'd2
  } hum_mode_t;

  // reset values of the registers
  localparam logic signed [11:0] OnTempRst    = 12'sd100;
  localparam logic signed [11:0] OffTempRst   = 12'sd600;
  localparam logic signed [11:0] HighTempRst  = 12'sd800;
  localparam logic [9:0]         OnHumRst     = 10'd100;
  localparam logic [9:0]         OffHumRst    = 10'd400;
  localparam logic [3:0]         WaitFactRst  = 4'd2;
  localparam logic [3:0]         WaitFactMax  = 4'd8;
  localparam logic [8:0]         IdleWaitSec  = 9'd60;
  localparam logic [5:0]         FanBoostSec  = 6'd10;

  typedef struct packed {
    logic signed [11:0] on_temp;
    logic signed [11:0] off_temp;
    logic signed [11:0] high_temp;
    logic [9:0]         on_hum;
    logic [9:0]         off_hum;
    logic               web_override;
    logic [3:0]         wait_factor;
  } cfg_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] wdata;
  } cfg_word_t;

  typedef struct packed {
    logic signed [11:0] temperature;
    logic [9:0]         humidity;
  } in_word_t;

  typedef struct packed {
    logic [1:0] temp_mode;
    logic [1:0] hum_mode;
    logic       relays_updated;
    logic [5:0] heater_seconds;
    logic [4:0] humidifier_seconds;
    logic [5:0] fan_seconds;
    logic       fan_commanded;
    logic [8:0] wait_seconds;
  } out_word_t;

  typedef struct packed {
    temp_mode_t temp_mode;
    hum_mode_t  hum_mode;
  } modes_t;

endpackage

FILE: hw/rtl/crs_cfg_if.sv
// ----------------------------------------------------------------------------
// crs_cfg_if
// Register write channel: valid/ready with index and write data.
// ----------------------------------------------------------------------------
interface crs_cfg_if;
  logic                valid;
  logic                ready;
  crs_pkg::cfg_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/crs_in_if.sv
// ----------------------------------------------------------------------------
// crs_in_if
// Sample channel: valid/ready with temperature and humidity.
// ----------------------------------------------------------------------------
interface crs_in_if;
  logic               valid;
  logic               ready;
  crs_pkg::in_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/crs_out_if.sv
// ----------------------------------------------------------------------------
// crs_out_if
// Result channel: valid/ready with modes and relay schedule.
// ----------------------------------------------------------------------------
interface crs_out_if;
  logic                valid;
  logic                ready;
  crs_pkg::out_word_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/crs_cfg_regs.sv
// ----------------------------------------------------------------------------
// crs_cfg_regs
// Threshold, override and wait factor registers.
// ----------------------------------------------------------------------------
module crs_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  crs_cfg_if.sink           cfg,
  output crs_pkg::cfg_t     regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.on_temp      <= crs_pkg::OnTempRst;
      regs.off_temp     <= crs_pkg::OffTempRst;
      regs.high_temp    <= crs_pkg::HighTempRst;
      regs.on_hum       <= crs_pkg::OnHumRst;
      regs.off_hum      <= crs_pkg::OffHumRst;
      regs.web_override <= 1'b0;
      regs.wait_factor  <= crs_pkg::WaitFactRst;
    end else if (cfg.valid) begin
      unique case (crs_pkg::cfg_idx_t'(cfg.data.index))
        crs_pkg::CFG_ON_TEMP:      regs.on_temp      <= $signed(cfg.data.wdata);
        crs_pkg::CFG_OFF_TEMP:     regs.off_temp     <= $signed(cfg.data.wdata);
        crs_pkg::CFG_HIGH_TEMP:    regs.high_temp    <= $signed(cfg.data.wdata);
        crs_pkg::CFG_ON_HUM:       regs.on_hum       <= cfg.data.wdata[9:0];
        crs_pkg::CFG_OFF_HUM:      regs.off_hum      <= cfg.data.wdata[9:0];
        crs_pkg::CFG_WEB_OVERRIDE: regs.web_override <= cfg.data.wdata[0];
        crs_pkg::CFG_WAIT_FACTOR:  regs.wait_factor  <= cfg.data.wdata[3:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

endmodule

FILE: hw/rtl/crs_mode_update.sv
// ----------------------------------------------------------------------------
// crs_mode_update
// Hysteresis mode registers and their next-mode decision.
// ----------------------------------------------------------------------------
module crs_mode_update (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  crs_pkg::in_word_t  sample,
  input  crs_pkg::cfg_t      regs,
  output crs_pkg::modes_t    modes_next
);

  crs_pkg::modes_t modes;
  logic signed [11:0] t;

  assign t = sample.temperature;

  always_comb begin
    modes_next = modes;
    // heat, then hold, then overheat; nothing matched keeps the mode
    if (t < regs.on_temp) begin
      modes_next.temp_mode = crs_pkg::TM_HEAT;
    end else if (t >= regs.off_temp && t < regs.high_temp) begin
      modes_next.temp_mode = crs_pkg::TM_HOLD;
    end else if (t >= regs.high_temp) begin
      modes_next.temp_mode = crs_pkg::TM_OVERHEAT;
    end
    if (sample.humidity < regs.on_hum) begin
      modes_next.hum_mode = crs_pkg::HM_HUMIDIFY;
    end else if (sample.humidity >= regs.off_hum) begin
      modes_next.hum_mode = crs_pkg::HM_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modes.temp_mode <= crs_pkg::TM_HOLD;
      modes.hum_mode  <= crs_pkg::HM_HOLD;
    end else if (advance) begin
      modes <= modes_next;
    end
  end

endmodule

FILE: hw/rtl/crs_relay_plan.sv
// ----------------------------------------------------------------------------
// crs_relay_plan
// Gap buckets, relay table and wait time for one sample.
// ----------------------------------------------------------------------------
module crs_relay_plan (
  input  crs_pkg::in_word_t   sample,
  input  crs_pkg::cfg_t       regs,
  input  crs_pkg::modes_t     modes,
  output crs_pkg::out_word_t  word
);

  logic signed [12:0] td;
  logic signed [10:0] hd;
  logic [5:0] heat_t;
  logic [4:0] hum_t;
  logic [5:0] fan_t;
  logic [3:0] fact;
  logic [5:0] base;
  logic [9:0] prod;
  logic       use_base;

  assign td = $signed({regs.off_temp[11], regs.off_temp})
            - $signed({sample.temperature[11], sample.temperature});
  assign hd = $signed({1'b0, regs.off_hum}) - $signed({1'b0, sample.humidity});

  always_comb begin
    if (td <= 13'sd3)       heat_t = 6'd10;
    else if (td <= 13'sd8)  heat_t = 6'd27;
    else if (td <= 13'sd15) heat_t = 6'd35;
    else if (td <= 13'sd20) heat_t = 6'd43;
    else                    heat_t = 6'd55;

    if (hd < 11'sd50)       hum_t = 5'd5;
    else if (hd < 11'sd100) hum_t = 5'd10;
    else if (hd < 11'sd150) hum_t = 5'd15;
    else if (hd < 11'sd200) hum_t = 5'd20;
    else                    hum_t = 5'd30;

    // fan bands above the setpoint; anything else, including small gaps, is 50
    if (td < -13'sd20 && td >= -13'sd40)       fan_t = 6'd10;
    else if (td < -13'sd40 && td >= -13'sd60)  fan_t = 6'd20;
    else if (td < -13'sd60 && td >= -13'sd80)  fan_t = 6'd30;
    else if (td < -13'sd80 && td >= -13'sd100) fan_t = 6'd40;
    else                                       fan_t = 6'd50;
  end

  assign fact = (regs.wait_factor > crs_pkg::WaitFactMax) ? crs_pkg::WaitFactMax
                                                          : regs.wait_factor;

  always_comb begin
    word                    = '0;
    word.temp_mode          = modes.temp_mode;
    word.hum_mode           = modes.hum_mode;
    word.wait_seconds       = crs_pkg::IdleWaitSec;
    base                    = '0;
    use_base                = 1'b0;
    if (!regs.web_override) begin
      word.relays_updated = 1'b1;
      case ({modes.temp_mode, modes.hum_mode})
        {crs_pkg::TM_HEAT, crs_pkg::HM_HUMIDIFY}: begin
          word.heater_seconds     = heat_t;
          word.humidifier_seconds = hum_t;
          word.fan_seconds        = heat_t;
          word.fan_commanded      = 1'b1;
          base     = (heat_t >= {1'b0, hum_t}) ? heat_t : {1'b0, hum_t};
          use_base = 1'b1;
        end
        {crs_pkg::TM_HOLD, crs_pkg::HM_HUMIDIFY}: begin
          word.humidifier_seconds = hum_t;
          word.fan_seconds        = {1'b0, hum_t};
          word.fan_commanded      = 1'b1;
          base     = {1'b0, hum_t};
          use_base = 1'b1;
        end
        {crs_pkg::TM_OVERHEAT, crs_pkg::HM_HUMIDIFY}: begin
          word.humidifier_seconds = hum_t;
          word.fan_seconds        = {1'b0, hum_t} + crs_pkg::FanBoostSec;
          word.fan_commanded      = 1'b1;
          base     = {1'b0, hum_t};
          use_base = 1'b1;
        end
        {crs_pkg::TM_OVERHEAT, crs_pkg::HM_HOLD}: begin
          word.fan_seconds   = fan_t;
          word.fan_commanded = 1'b1;
          base     = fan_t;
          use_base = 1'b1;
        end
        {crs_pkg::TM_HEAT, crs_pkg::HM_HOLD}: begin
          word.heater_seconds = heat_t;
          base     = heat_t;
          use_base = 1'b1;
        end
        default: ;  // both holding, or an unreachable pair: idle wait
      endcase
    end
    prod = base * fact;
    if (use_base) word.wait_seconds = prod[8:0];
  end

endmodule

FILE: hw/rtl/climate_relay_scheduler_top.sv
// ----------------------------------------------------------------------------
// climate_relay_scheduler_top
// Hysteresis climate control: one sensor word in, one relay schedule out.
//   cfg     : register writes (index 0..6), always ready.
//   samples : temperature/humidity word, valid/ready.
//   results : modes after update plus heater, humidifier, fan on-times and
//             the wait before the next sample, valid/ready.
// A taken word passes the input stage, then the result register, to results.
// Throughput: one word per cycle; the input stage and the result register
// form a two-entry pipeline, so a new word is taken while a finished result
// waits. The user has cfg writes taken only while idle; not enforced.
// Receiver stall: the result holds, the input stage fills, then samples.ready
// drops until results.ready returns.
// Reset (rst, synchronous): pipeline emptied, both modes go to hold,
// registers to their defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module climate_relay_scheduler_top (
  input  logic      clk,
  input  logic      rst,
  crs_cfg_if.sink   cfg,
  crs_in_if.sink    samples,
  crs_out_if.source results
);

  crs_pkg::cfg_t      regs;
  crs_pkg::in_word_t  s1_data;
  logic               s1_valid;
  logic               s1_adv;
  crs_pkg::modes_t    modes_next;
  crs_pkg::out_word_t plan;
  crs_pkg::out_word_t r_data;
  logic               r_valid;

  crs_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // stage 1 moves on when the result register is empty or being drained
  assign s1_adv        = s1_valid && (!r_valid || results.ready);
  assign samples.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (samples.ready) begin
      s1_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      s1_data <= samples.data;
    end
  end

  // mode state commits only as the word leaves stage 1
  crs_mode_update u_mode (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_adv),
    .sample     (s1_data),
    .regs       (regs),
    .modes_next (modes_next)
  );

  crs_relay_plan u_plan (
    .sample (s1_data),
    .regs   (regs),
    .modes  (modes_next),
    .word   (plan)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (s1_adv) begin
      r_valid <= 1'b1;
    end else if (results.ready) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      r_data <= plan;
    end
  end

  assign results.valid = r_valid;
  assign results.data  = r_data;

  // suppressed relays: everything off, fixed idle wait
  `CRS_ASSERT(a_override_idle,
    r_valid && !r_data.relays_updated |-> r_data.heater_seconds == '0 &&
      r_data.humidifier_seconds == '0 && r_data.fan_seconds == '0 &&
      !r_data.fan_commanded && r_data.wait_seconds == crs_pkg::IdleWaitSec,
    "override result carries relay activity")
  // fan time only travels with a fan command
  `CRS_ASSERT(a_fan_cmd,
    r_valid && !r_data.fan_commanded |-> r_data.fan_seconds == '0,
    "fan time without fan command")
  // no word is taken while both stages are full and the receiver stalls
  `CRS_ASSERT(a_no_overrun,
    s1_valid && r_valid && !results.ready |-> !samples.ready,
    "input accepted into a full pipeline")
  // after reset the pipeline is empty
  `CRS_ASSERT_ALWAYS(a_reset_empty,
    rst |=> !s1_valid && !r_valid,
    "pipeline not empty after reset")

endmodule

FILE: tb/relay_schedule_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_schedule_checker
// Watches the register, sample and result channels of the climate relay
// scheduler. Keeps its own copy of the registers and hysteresis modes and
// predicts one relay schedule per sample. Each result word is compared field
// by field with the oldest prediction.
// ----------------------------------------------------------------------------
module relay_schedule_checker
  import crs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  crs_cfg_if   cfg,
  crs_in_if    samples,
  crs_out_if   results,
  output int   errors,
  output int   pending
);

  cfg_t       regs;
  temp_mode_t tmode;
  hum_mode_t  hmode;
  out_word_t  expected_schedules[$];
  int         mismatches = 0;
  int         result_no  = 0;

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("checker: result %0d: %s", result_no, msg);
  endtask

  task automatic check_field(string name, logic [8:0] got, logic [8:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Updates the modes, then looks up the relay schedule for the new pair.
  function automatic out_word_t advance_schedule(in_word_t s);
    int        t, h, td, hd, f;
    int        heat_s, humid_s, fan_s;
    out_word_t r;
    t = $signed(s.temperature);
    h = s.humidity;
    f = (regs.wait_factor > WaitFactMax) ? WaitFactMax : regs.wait_factor;

    // heat wins over hold wins over overheat; no match keeps the mode
    if (t < $signed(regs.on_temp)) tmode = TM_HEAT;
    else if (t >= $signed(regs.off_temp) && t < $signed(regs.high_temp)) tmode = TM_HOLD;
    else if (t >= $signed(regs.high_temp)) tmode = TM_OVERHEAT;
    if (h < int'(regs.on_hum)) hmode = HM_HUMIDIFY;
    else if (h >= int'(regs.off_hum)) hmode = HM_HOLD;

    r = '0;
    r.temp_mode    = tmode;
    r.hum_mode     = hmode;
    r.wait_seconds = IdleWaitSec;
    if (!regs.web_override) begin
      td = $signed(regs.off_temp) - t;
      hd = int'(regs.off_hum) - h;
      if (td <= 3) heat_s = 10;
      else if (td <= 8) heat_s = 27;
      else if (td <= 15) heat_s = 35;
      else if (td <= 20) heat_s = 43;
      else heat_s = 55;
      if (hd < 50) humid_s = 5;
      else if (hd < 100) humid_s = 10;
      else if (hd < 150) humid_s = 15;
      else if (hd < 200) humid_s = 20;
      else humid_s = 30;
      // fan buckets only below -20; everything else is the long run
      if (td < -20 && td >= -40) fan_s = 10;
      else if (td < -40 && td >= -60) fan_s = 20;
      else if (td < -60 && td >= -80) fan_s = 30;
      else if (td < -80 && td >= -100) fan_s = 40;
      else fan_s = 50;
      r.relays_updated = 1'b1;
      case ({tmode, hmode})
        {TM_HEAT, HM_HUMIDIFY}: begin
          r.heater_seconds     = 6'(heat_s);
          r.humidifier_seconds = 5'(humid_s);
          r.fan_seconds        = 6'(heat_s);
          r.fan_commanded      = 1'b1;
          r.wait_seconds       = 9'((heat_s >= humid_s ? heat_s : humid_s) * f);
        end
        {TM_HOLD, HM_HUMIDIFY}: begin
          r.humidifier_seconds = 5'(humid_s);
          r.fan_seconds        = 6'(humid_s);
          r.fan_commanded      = 1'b1;
          r.wait_seconds       = 9'(humid_s * f);
        end
        {TM_OVERHEAT, HM_HUMIDIFY}: begin
          r.humidifier_seconds = 5'(humid_s);
          r.fan_seconds        = 6'(humid_s + FanBoostSec);
          r.fan_commanded      = 1'b1;
          r.wait_seconds       = 9'(humid_s * f);
        end
        {TM_OVERHEAT, HM_HOLD}: begin
          r.fan_seconds   = 6'(fan_s);
          r.fan_commanded = 1'b1;
          r.wait_seconds  = 9'(fan_s * f);
        end
        {TM_HEAT, HM_HOLD}: begin
          r.heater_seconds = 6'(heat_s);
          r.wait_seconds   = 9'(heat_s * f);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t got, want;
    if (rst) begin
      regs  = '{OnTempRst, OffTempRst, HighTempRst, OnHumRst, OffHumRst, 1'b0, WaitFactRst};
      tmode = TM_HOLD;
      hmode = HM_HOLD;
      expected_schedules.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.data.index)
          CFG_ON_TEMP:      regs.on_temp      = cfg.data.wdata;
          CFG_OFF_TEMP:     regs.off_temp     = cfg.data.wdata;
          CFG_HIGH_TEMP:    regs.high_temp    = cfg.data.wdata;
          CFG_ON_HUM:       regs.on_hum       = cfg.data.wdata[9:0];
          CFG_OFF_HUM:      regs.off_hum      = cfg.data.wdata[9:0];
          CFG_WEB_OVERRIDE: regs.web_override = cfg.data.wdata[0];
          CFG_WAIT_FACTOR:  regs.wait_factor  = cfg.data.wdata[3:0];
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        result_no++;
        got = results.data;
        if (expected_schedules.size() == 0) begin
          report_mismatch("word with no sample outstanding");
        end else begin
          want = expected_schedules.pop_front();
          check_field("temp_mode", got.temp_mode, want.temp_mode);
          check_field("hum_mode", got.hum_mode, want.hum_mode);
          check_field("relays_updated", got.relays_updated, want.relays_updated);
          check_field("heater_seconds", got.heater_seconds, want.heater_seconds);
          check_field("humidifier_seconds", got.humidifier_seconds, want.humidifier_seconds);
          check_field("fan_seconds", got.fan_seconds, want.fan_seconds);
          check_field("fan_commanded", got.fan_commanded, want.fan_commanded);
          check_field("wait_seconds", got.wait_seconds, want.wait_seconds);
        end
      end
      if (samples.valid && samples.ready)
        expected_schedules.push_back(advance_schedule(samples.data));
    end
    pending <= expected_schedules.size();
    errors  <= mismatches;
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the climate relay scheduler: register settings, a directed sample
// set over the mode table and bucket edges, then random sample runs under a
// series of register settings. Both channels idle at random. The checker
// beside the block predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import crs_pkg::*;

  // cycles without any handshake before the run is declared hung
  localparam int QuietLimit = 1000;
  localparam int Phases     = 12;
  localparam int PhaseWords = 77;

  logic clk;
  logic rst;
  int   mismatch_count;
  int   outstanding;
  int   quiet     = 0;
  int   send_calm = 0;
  int   sink_calm = 0;
  cfg_t programmed;  // register values last loaded, used to aim samples

  crs_cfg_if cfg_ch ();
  crs_in_if  sample_ch ();
  crs_out_if result_ch ();

  climate_relay_scheduler_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (sample_ch),
    .results (result_ch)
  );

  relay_schedule_checker i_checker (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (sample_ch),
    .results (result_ch),
    .errors  (mismatch_count),
    .pending (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Per-word random idle draw. Now and then a calm stretch of
  // back-to-back words so the pipeline also runs full.
  task automatic draw_gap(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(20, 60);
      gap  = 0;
    end else begin
      gap = $urandom_range(0, 10);
    end
  endtask

  // One register write; valid stays high so writes can go back to back.
  task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= {idx, value};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  // One sample word. Returns on the edge that took it.
  task automatic send_sample(int t, int h);
    int gap;
    draw_gap(send_calm, gap);
    if (gap > 0) begin
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid <= 1'b1;
    sample_ch.data  <= {12'(t), 10'(h)};
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait for every predicted schedule to come back. The
  // first edge lets the checker see the last word taken.
  task automatic settle();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Registers only change with the pipeline empty. Unused upper data bits
  // get random values; the block must ignore them.
  task automatic load_settings(cfg_t s);
    settle();
    write_reg(CFG_ON_TEMP, s.on_temp);
    write_reg(CFG_OFF_TEMP, s.off_temp);
    write_reg(CFG_HIGH_TEMP, s.high_temp);
    write_reg(CFG_ON_HUM, {2'($urandom), s.on_hum});
    write_reg(CFG_OFF_HUM, {2'($urandom), s.off_hum});
    write_reg(CFG_WEB_OVERRIDE, {11'($urandom), s.web_override});
    write_reg(CFG_WAIT_FACTOR, {8'($urandom), s.wait_factor});
    cfg_ch.valid <= 1'b0;
    programmed = s;
  endtask

  // Settings per random phase: defaults, the extremes, odd threshold order,
  // override, then a mix of ordered and fully random settings.
  function automatic cfg_t settings_for(int phase);
    cfg_t s;
    int   lo;
    s = '{OnTempRst, OffTempRst, HighTempRst, OnHumRst, OffHumRst, 1'b0, WaitFactRst};
    case (phase)
      0: ;
      1: s = '{12'h7FF, 12'h7FF, 12'h7FF, 10'h3FF, 10'h3FF, 1'b0, 4'hF};
      2: s = '{12'h800, 12'h800, 12'h800, 10'h000, 10'h000, 1'b0, 4'h0};
      3: s = '{12'h7FF, 12'h800, 12'h000, 10'h3FF, 10'h000, 1'b0, WaitFactMax};
      4: begin
        s.web_override = 1'b1;
        s.wait_factor  = 4'd1;
      end
      default: begin
        if (phase % 3 == 0) begin
          s.on_temp      = 12'($urandom);
          s.off_temp     = 12'($urandom);
          s.high_temp    = 12'($urandom);
          s.on_hum       = 10'($urandom);
          s.off_hum      = 10'($urandom);
          s.web_override = 1'($urandom);
          s.wait_factor  = 4'($urandom);
        end else begin
          lo = int'($urandom_range(0, 1650)) - 400;
          s.on_temp      = 12'(lo);
          s.off_temp     = 12'(lo + int'($urandom_range(0, 300)));
          s.high_temp    = 12'(lo + int'($urandom_range(300, 700)));
          lo = $urandom_range(0, 700);
          s.on_hum       = 10'(lo);
          s.off_hum      = 10'(lo + int'($urandom_range(0, 300)));
          s.web_override = ($urandom_range(0, 5) == 0);
          s.wait_factor  = 4'($urandom_range(1, 8));
        end
      end
    endcase
    return s;
  endfunction

  // Result side: random stall before each word, with calm stretches too.
  initial begin : result_sink
    int stall;
    result_ch.ready <= 1'b0;
    forever begin
      draw_gap(sink_calm, stall);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  // Hang detection: any handshake on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (cfg_ch.valid && cfg_ch.ready) || (sample_ch.valid && sample_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    cfg_t s;
    int   t, h, base;
    rst             <= 1'b1;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    sample_ch.valid <= 1'b0;
    sample_ch.data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed, default thresholds (100/600/800, 100/400, factor 2).
    load_settings(settings_for(0));
    send_sample(700, 500);     // hold/hold: nothing runs, wait 60
    send_sample(50, 500);      // heat only, large gap
    send_sample(50, 50);       // heat and humidify
    send_sample(597, 351);     // heater edge 3, humidifier edge 49
    send_sample(596, 350);     // just past both first edges
    send_sample(591, 300);     // heater 9, humidifier 100
    send_sample(585, 250);     // heater 15, humidifier 150
    send_sample(580, 200);     // heater 20, humidifier 200
    send_sample(579, 0);       // heater 21, humidity at zero
    send_sample(100, 100);     // both exactly at the on thresholds: modes kept
    send_sample(650, 399);     // hold, still humidifying
    send_sample(900, 150);     // overheat while humidifying: fan boosted
    send_sample(2047, 1023);   // top of both fields: overheat, hold
    send_sample(-2048, 0);     // bottom of both fields
    send_sample(600, 400);     // exactly at both off thresholds
    send_sample(800, 1000);    // exactly at overheat

    // Fan buckets: overheat from 600, factor 8 gives the longest waits.
    s = settings_for(0);
    s.high_temp   = 12'sd600;
    s.wait_factor = WaitFactMax;
    load_settings(s);
    send_sample(620, 1000);
    send_sample(621, 1000);
    send_sample(641, 1000);
    send_sample(661, 1000);
    send_sample(681, 1000);
    send_sample(701, 1000);

    // Override: modes move, relays stay put, wait is the fixed 60.
    s = settings_for(0);
    s.web_override = 1'b1;
    s.wait_factor  = 4'hF;
    load_settings(s);
    send_sample(50, 50);
    send_sample(900, 1023);
    // factor above 8 saturates
    s.web_override = 1'b0;
    load_settings(s);
    send_sample(50, 50);
    // factor 0 zeroes scaled waits but not the fixed one
    s.wait_factor = 4'h0;
    load_settings(s);
    send_sample(50, 50);
    send_sample(700, 500);

    // Random runs: most samples land near a threshold so the modes walk
    // through their hysteresis; the rest span the whole field.
    for (int phase = 0; phase < Phases; phase++) begin
      load_settings(settings_for(phase));
      repeat (PhaseWords) begin
        if ($urandom_range(0, 4) == 0) begin
          t = $urandom_range(0, 4095);
        end else begin
          case ($urandom_range(0, 2))
            0:       base = $signed(programmed.on_temp);
            1:       base = $signed(programmed.off_temp);
            default: base = $signed(programmed.high_temp);
          endcase
          t = base + int'($urandom_range(0, 240)) - 120;
        end
        if ($urandom_range(0, 4) == 0) begin
          h = $urandom_range(0, 1023);
        end else begin
          base = ($urandom_range(0, 1) == 0) ? int'(programmed.on_hum) : int'(programmed.off_hum);
          h = base + int'($urandom_range(0, 520)) - 260;
        end
        send_sample(t, h);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
